@@ hdl/lin_master_frame_builder_assert.svh @@
// ----------------------------------------------------------------------------
// LIN frame builder assertion macros
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LIN_MASTER_FRAME_BUILDER_ASSERT_SVH
`define LIN_MASTER_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmfb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LMFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmfb assertion failed");

`endif

@@ hdl/lmfb_pkg.sv @@
// ----------------------------------------------------------------------------
// LIN frame builder package
// Shared command and status types, frame constants and identifier parity.
// ----------------------------------------------------------------------------
package lmfb_pkg;

  localparam logic       ModeHeader = 1'b0;
  localparam logic       ModeData   = 1'b1;
  localparam logic [7:0] SyncByte   = 8'h55;
  localparam logic [7:0] EmptyChk   = 8'hFF;

  // One classified item as handed from the front end to the back end.
  typedef struct packed {
    logic       is_data;  // 1: data byte, 0: header
    logic [7:0] value;    // data byte or protected identifier
    logic       flag;     // data: last byte; header: empty frame
    logic [7:0] chk;      // inverted checksum to send when the frame closes
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Protected identifier: id in bits 5..0, P0 in bit 6, P1 in bit 7.
  function automatic logic [7:0] protect_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

@@ hdl/lmfb_if.sv @@
// ----------------------------------------------------------------------------
// LIN frame builder channels
// Valid/ready interfaces for the item input and the byte output.
// ----------------------------------------------------------------------------
interface lmfb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [5:0] frame_id;
  logic       empty_frame;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, mode, frame_id, empty_frame, data_byte, last_byte,
                  input ready);
  modport sink   (input valid, mode, frame_id, empty_frame, data_byte, last_byte,
                  output ready);
endinterface

interface lmfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       send_break;
  logic       last;

  modport source (output valid, tx_byte, send_break, last, input ready);
  modport sink   (input valid, tx_byte, send_break, last, output ready);
endinterface

@@ hdl/lmfb_front.sv @@
// ----------------------------------------------------------------------------
// LIN frame builder front end
// Accepts items, tracks the open frame and the checksum, queues commands.
// ----------------------------------------------------------------------------
module lmfb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  lmfb_in_if.sink            in_i,
  input  lmfb_pkg::q_stat_t  q_stat_i,
  output logic               push_o,
  output lmfb_pkg::cmd_t     cmd_o
);

  logic [7:0] running_sum_q, running_sum_d;
  logic       in_frame_q, in_frame_d;
  logic       accept;
  logic [8:0] raw_sum;
  logic [7:0] new_sum;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  // End-around carry: a carry out wraps back into bit 0.
  assign raw_sum = {1'b0, running_sum_q} + {1'b0, in_i.data_byte};
  assign new_sum = raw_sum[8] ? (raw_sum[7:0] + 8'd1) : raw_sum[7:0];

  always_comb begin
    running_sum_d = running_sum_q;
    in_frame_d    = in_frame_q;
    push_o        = 1'b0;
    cmd_o.is_data = in_i.mode;
    cmd_o.flag    = 1'b0;
    cmd_o.value   = in_i.data_byte;
    cmd_o.chk     = ~new_sum;
    if (in_i.mode == lmfb_pkg::ModeHeader) begin
      cmd_o.value = lmfb_pkg::protect_id(in_i.frame_id);
      cmd_o.flag  = in_i.empty_frame;
      cmd_o.chk   = lmfb_pkg::EmptyChk;
      if (accept) begin
        push_o        = 1'b1;
        running_sum_d = 8'd0;
        in_frame_d    = !in_i.empty_frame;
      end
    end else begin
      cmd_o.flag = in_i.last_byte;
      // Drop data that arrives with no frame open.
      if (accept && in_frame_q) begin
        push_o = 1'b1;
        if (in_i.last_byte) begin
          running_sum_d = 8'd0;
          in_frame_d    = 1'b0;
        end else begin
          running_sum_d = new_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= 8'd0;
      in_frame_q    <= 1'b0;
    end else begin
      running_sum_q <= running_sum_d;
      in_frame_q    <= in_frame_d;
    end
  end

endmodule

@@ hdl/lmfb_queue.sv @@
// ----------------------------------------------------------------------------
// LIN frame builder command queue
// Small first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module lmfb_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lmfb_pkg::cmd_t     cmd_i,
  input  logic               pop_i,
  output lmfb_pkg::cmd_t     head_o,
  output lmfb_pkg::q_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lmfb_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/lmfb_back.sv @@
// ----------------------------------------------------------------------------
// LIN frame builder back end
// Expands queued commands into transmit bytes through an output register.
// ----------------------------------------------------------------------------
module lmfb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lmfb_pkg::cmd_t     cmd_i,
  input  lmfb_pkg::q_stat_t  q_stat_i,
  output logic               pop_o,
  lmfb_out_if.source         out_o
);

  localparam logic [1:0] StFirst = 2'd0;
  localparam logic [1:0] StSync  = 2'd1;
  localparam logic [1:0] StPid   = 2'd2;
  localparam logic [1:0] StChk   = 2'd3;

  logic [1:0] step_q, step_d, step_nxt;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_c;
  logic       brk_q, brk_c;
  logic       last_q, last_c;
  logic       advance;

  assign advance = !q_stat_i.empty && (!valid_q || out_o.ready);

  always_comb begin
    byte_c   = 8'd0;
    brk_c    = 1'b0;
    last_c   = 1'b0;
    step_nxt = StFirst;
    unique case (step_q)
      StFirst: begin
        if (cmd_i.is_data) begin
          byte_c   = cmd_i.value;
          last_c   = !cmd_i.flag;
          step_nxt = cmd_i.flag ? StChk : StFirst;
        end else begin
          brk_c    = 1'b1;
          step_nxt = StSync;
        end
      end
      StSync: begin
        byte_c   = lmfb_pkg::SyncByte;
        step_nxt = StPid;
      end
      StPid: begin
        byte_c   = cmd_i.value;
        last_c   = !cmd_i.flag;
        step_nxt = cmd_i.flag ? StChk : StFirst;
      end
      StChk: begin
        byte_c   = cmd_i.chk;
        last_c   = 1'b1;
        step_nxt = StFirst;
      end
      default: begin
        step_nxt = StFirst;
      end
    endcase
  end

  // Pop once the final byte of the command is loaded.
  assign pop_o   = advance && last_c;
  assign step_d  = advance ? step_nxt : step_q;
  assign valid_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StFirst;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_c;
      brk_q  <= brk_c;
      last_q <= last_c;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.tx_byte    = byte_q;
  assign out_o.send_break = brk_q;
  assign out_o.last       = last_q;

endmodule

@@ hdl/lin_master_frame_builder.sv @@
// ----------------------------------------------------------------------------
// LIN master frame builder
// Turns header and data items into the byte stream of a LIN master frame.
//
// in_i carries one item per transaction: a header (mode 0) with frame_id and
// empty_frame, or a data byte (mode 1) with last_byte. out_o carries one
// transmit byte per transaction, or a break marker when send_break is set;
// last flags the final byte caused by an item.
// A header yields break, sync 0x55 and the protected identifier, plus the
// checksum 0xFF when empty. A data byte yields itself, plus the inverted
// classic checksum when it is the last one. Data outside a frame is dropped.
// The first byte of an item is written into the command queue and then
// loaded into the output register. The output register gives one output
// transaction per cycle while the receiver is ready and a command is queued,
// as the back end's byte sequencer steps through each item. Items queue up
// in a Depth-entry command queue while the back end works, and in_i.ready
// drops only when it is full. When the receiver stalls, the output register
// holds its byte and the queue absorbs new items. Reset clears the queue,
// the open frame and the checksum; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "lin_master_frame_builder_assert.svh"

module lin_master_frame_builder #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmfb_in_if.sink     in_i,
  lmfb_out_if.source  out_o
);

  lmfb_pkg::cmd_t    cmd_in;
  lmfb_pkg::cmd_t    cmd_head;
  lmfb_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  // Front end: classify, keep checksum and frame state, push commands.
  lmfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  // Decouple item acceptance from byte emission.
  lmfb_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .head_o (cmd_head),
    .stat_o (q_stat)
  );

  // Back end: step through the bytes of each command.
  lmfb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // Never push into a full queue nor pop an empty one.
  `LMFB_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push, !q_stat.full)
  `LMFB_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop, !q_stat.empty)
  // A break marker opens a header and never ends an item.
  `LMFB_ASSERT_NOW(a_break_shape, clk_i, rst_ni, out_o.valid && out_o.send_break,
                   out_o.tx_byte == 8'd0 && !out_o.last)

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIN master frame builder testbench
// Drives header and data items with random gaps, predicts every transmit
// byte (break, sync, protected id, payload, classic checksum) and compares
// each output transaction against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_top;

  // One input item as it travels on in_i.
  typedef struct packed {
    logic       mode;
    logic [5:0] frame_id;
    logic       empty_frame;
    logic [7:0] data_byte;
    logic       last_byte;
  } lin_item_t;

  // One transmit byte as it appears on out_o.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       send_break;
    logic       last;
  } tx_word_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 12;

  logic clk;
  logic rst_n;

  lmfb_in_if  in_ch ();
  lmfb_out_if out_ch ();

  lin_master_frame_builder uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Items waiting to be driven, and bytes the builder still owes us.
  lin_item_t item_q[$];
  tx_word_t  tx_expect_q[$];

  // Predictor state: classic checksum accumulator and open-frame flag.
  logic [7:0] chk_sum;
  logic       frame_open;

  int unsigned err_cnt;
  int unsigned items_taken;
  int unsigned bytes_seen;
  int unsigned cycle_cnt;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold every input at a known value from time zero, then release reset.
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = lmfb_pkg::ModeHeader;
    in_ch.frame_id     = '0;
    in_ch.empty_frame  = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Protected identifier: P0 = even parity of id bits 0,1,2,4 in bit 6,
  // P1 = odd parity of id bits 1,3,4,5 in bit 7.
  function automatic logic [7:0] pid_of(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = ^{id[0], id[1], id[2], id[4]};
    p1 = ~(^{id[1], id[3], id[4], id[5]});
    return {p1, p0, id};
  endfunction

  // Push one predicted byte onto the expectation queue.
  function automatic void owe_byte(input logic [7:0] b, input logic brk, input logic lst);
    tx_word_t w;
    w.tx_byte    = b;
    w.send_break = brk;
    w.last       = lst;
    tx_expect_q.push_back(w);
  endfunction

  // Work out the bytes that one accepted item causes and advance the
  // predicted frame state.
  function automatic void build_frame_bytes(input lin_item_t it);
    logic [8:0] wide_sum;
    if (it.mode == lmfb_pkg::ModeHeader) begin
      // A header always restarts the checksum; an open frame is abandoned.
      chk_sum = '0;
      owe_byte(8'h00, 1'b1, 1'b0);
      owe_byte(lmfb_pkg::SyncByte, 1'b0, 1'b0);
      if (it.empty_frame) begin
        owe_byte(pid_of(it.frame_id), 1'b0, 1'b0);
        owe_byte(~chk_sum, 1'b0, 1'b1);
        frame_open = 1'b0;
      end else begin
        owe_byte(pid_of(it.frame_id), 1'b0, 1'b1);
        frame_open = 1'b1;
      end
    end else if (frame_open) begin
      // Classic checksum: 8-bit add with end-around carry.
      wide_sum = {1'b0, chk_sum} + {1'b0, it.data_byte};
      if (wide_sum > 9'h0FF) begin
        wide_sum = wide_sum - 9'h0FF;
      end
      chk_sum = wide_sum[7:0];
      if (it.last_byte) begin
        owe_byte(it.data_byte, 1'b0, 1'b0);
        owe_byte(~chk_sum, 1'b0, 1'b1);
        chk_sum    = '0;
        frame_open = 1'b0;
      end else begin
        owe_byte(it.data_byte, 1'b0, 1'b1);
      end
    end
    // Data outside a frame: dropped, nothing owed.
  endfunction

  // --------------------------------------------------------------------------
  // Driver: feed item_q onto in_i, with random gaps outside a steady window
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lin_item_t nxt;
    logic      steady;
    if (!rst_n) begin
      chk_sum     = '0;
      frame_open  = 1'b0;
      items_taken = 0;
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // A transaction completed on this edge: predict from what was driven.
      if (in_ch.valid) begin
        build_frame_bytes({in_ch.mode, in_ch.frame_id, in_ch.empty_frame,
                           in_ch.data_byte, in_ch.last_byte});
        items_taken++;
      end
      steady = (items_taken >= 40) && (items_taken < 75);
      if (item_q.size() > 0 && (steady || $urandom_range(99) >= 35)) begin
        nxt = item_q.pop_front();
        in_ch.mode        <= nxt.mode;
        in_ch.frame_id    <= nxt.frame_id;
        in_ch.empty_frame <= nxt.empty_frame;
        in_ch.data_byte   <= nxt.data_byte;
        in_ch.last_byte   <= nxt.last_byte;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each output transaction, stall out_o at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    tx_word_t want;
    tx_word_t got;
    logic     steady;
    if (!rst_n) begin
      bytes_seen   = 0;
      err_cnt      = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.tx_byte, out_ch.send_break, out_ch.last};
        bytes_seen++;
        if (tx_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected byte: expected none, actual tx_byte=%h brk=%b last=%b",
                   $time, got.tx_byte, got.send_break, got.last);
        end else begin
          want = tx_expect_q.pop_front();
          if (got.tx_byte !== want.tx_byte) begin
            err_cnt++;
            $display("%0t: tx_byte mismatch: expected %h, actual %h",
                     $time, want.tx_byte, got.tx_byte);
          end
          if (got.send_break !== want.send_break) begin
            err_cnt++;
            $display("%0t: send_break mismatch: expected %b, actual %b",
                     $time, want.send_break, got.send_break);
          end
          if (got.last !== want.last) begin
            err_cnt++;
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, got.last);
          end
        end
      end
      // Keep the receiver always ready through one stretch of the run.
      steady = (bytes_seen >= 100) && (bytes_seen < 200);
      out_ch.ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** lin_master_frame_builder: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  // Queue one item; fields the item kind ignores get random noise.
  task automatic queue_item(input logic md, input logic [5:0] id, input logic emp,
                            input logic [7:0] b, input logic lst);
    lin_item_t it;
    it.mode        = md;
    it.frame_id    = (md == lmfb_pkg::ModeHeader) ? id  : 6'($urandom_range(63));
    it.empty_frame = (md == lmfb_pkg::ModeHeader) ? emp : 1'($urandom_range(1));
    it.data_byte   = (md == lmfb_pkg::ModeData)   ? b   : 8'($urandom_range(255));
    it.last_byte   = (md == lmfb_pkg::ModeData)   ? lst : 1'($urandom_range(1));
    item_q.push_back(it);
  endtask

  initial begin
    int unsigned n_rand;
    int unsigned n_total;
    int unsigned len;
    logic        open;
    logic        close;
    cycle_cnt = 0;

    // Directed part.
    // Data before any header: dropped.
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'hA5, 1'b1);
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'h5A, 1'b0);
    // Lowest id; bytes that force the end-around carry.
    queue_item(lmfb_pkg::ModeHeader, 6'd0, 1'b0, 8'h00, 1'b0);
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'hFF, 1'b0);
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'hFF, 1'b0);
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'h01, 1'b1);
    // Highest id, empty frame: checksum follows the header at once.
    queue_item(lmfb_pkg::ModeHeader, 6'd63, 1'b1, 8'h00, 1'b0);
    // Frame left closed by the empty header: dropped.
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'h33, 1'b0);
    // Header while a frame is open abandons it.
    queue_item(lmfb_pkg::ModeHeader, 6'h2A, 1'b0, 8'h00, 1'b0);
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'h80, 1'b0);
    queue_item(lmfb_pkg::ModeHeader, 6'h15, 1'b0, 8'h00, 1'b0);
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'h00, 1'b1);
    // Single-byte frame with an all-ones payload.
    queue_item(lmfb_pkg::ModeHeader, 6'd63, 1'b0, 8'h00, 1'b0);
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'hFF, 1'b1);
    // Empty header at the lowest id.
    queue_item(lmfb_pkg::ModeHeader, 6'd0, 1'b1, 8'h00, 1'b0);
    // Header with no data, then another header.
    queue_item(lmfb_pkg::ModeHeader, 6'h01, 1'b0, 8'h00, 1'b0);
    queue_item(lmfb_pkg::ModeHeader, 6'h3C, 1'b0, 8'h00, 1'b0);
    queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'h7E, 1'b1);

    // Random part: mostly well-formed frames with random content, some
    // abandoned frames and some stray data outside a frame.
    n_rand = 0;
    open   = 1'b0;
    while (n_rand < 100) begin
      if (!open && $urandom_range(99) < 8) begin
        queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end else if ($urandom_range(99) < 12) begin
        queue_item(lmfb_pkg::ModeHeader, 6'($urandom_range(63)), 1'b1, 8'h00, 1'b0);
        n_rand++;
        open = 1'b0;
      end else begin
        queue_item(lmfb_pkg::ModeHeader, 6'($urandom_range(63)), 1'b0, 8'h00, 1'b0);
        n_rand++;
        len   = $urandom_range(5);
        close = ($urandom_range(99) < 85);
        for (int unsigned i = 0; i < len; i++) begin
          queue_item(lmfb_pkg::ModeData, 6'd0, 1'b0, 8'($urandom_range(255)),
                     close && (i == len - 1));
          n_rand++;
        end
        open = !(close && len > 0);
      end
    end
    n_total = item_q.size();

    // Wait for every item to be accepted and every owed byte to come out,
    // then let the pipeline settle in case the final items were dropped ones.
    while (items_taken < n_total || tx_expect_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DrainWait) @(posedge clk);

    if (err_cnt == 0 && tx_expect_q.size() == 0) begin
      $display("** lin_master_frame_builder: PASSED **");
    end else begin
      if (tx_expect_q.size() > 0) begin
        $display("%0t: %0d expected bytes never arrived", $time, tx_expect_q.size());
      end
      $display("** lin_master_frame_builder: FAILED **");
    end
    $finish;
  end

endmodule
